[sv/rrhl_pkg.sv]
// ----------------------------------------------------------------------------
// rrhl_pkg
// Shared constants, types and arithmetic helpers of the ray/rectangle hit
// locator: fixed-point widths, CORDIC tables, angle folding and rounding.
// ----------------------------------------------------------------------------
package rrhl_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int CW        = FRAC_BITS + 3;
  localparam int ZW        = 31;
  localparam int ANG_SHIFT = 16;
  localparam int AGW       = 19;
  localparam int VW        = FRAC_BITS + 4;
  localparam int MW        = 2 * VW;
  localparam int PW        = 2 * VW + 2;

  localparam int DW        = 16;
  localparam int TW        = 15;
  localparam int YAW_W     = 16;
  localparam int ALT_W     = 16;
  localparam int AZ_W      = 17;
  localparam int QW        = 16;
  localparam int AW        = DW + VW;
  localparam int REG_IDX_W = 3;

  localparam int NLANE       = 5;
  localparam int LANE_YAW    = 0;
  localparam int LANE_TILT   = 1;
  localparam int LANE_W      = 2;
  localparam int LANE_ALT    = 3;
  localparam int LANE_AZ     = 4;

  localparam int GEOM_STAGES = 10;
  localparam int DIV_STAGES  = QW;

  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;

  localparam logic [DW-1:0]        DIST_RST = DW'(1000);
  localparam logic [DW-1:0]        LEN_RST  = DW'(1400);
  localparam logic [DW-1:0]        HGT_RST  = DW'(800);
  localparam logic signed [TW-1:0] TILT_RST = TW'(-6000);

  localparam longint          RAD_UNITS = 64'sd375493621;
  localparam longint unsigned GAIN_Q32  = 64'd2608131496;
  localparam longint unsigned X0_L =
    (GAIN_Q32 * (64'd1 << FRAC_BITS) + 64'h8000_0000) >> 32;
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(X0_L);

  localparam longint unsigned PAR_L =
    ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [VW-1:0] PAR_THR = (PAR_L == 0) ? VW'(1) : VW'(PAR_L);

  localparam int ATAN_N = 11;
  localparam longint ATAN_TAB [ATAN_N] = '{
    64'sd294912000, 64'sd174096719, 64'sd91987925, 64'sd46694507,
    64'sd23437865,  64'sd11730358,  64'sd5866610,  64'sd2933484,
    64'sd1466764,   64'sd733385,    64'sd366693
  };

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DISTANCE = 3'd0,
    REG_LENGTH   = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_TILT     = 3'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    HIT_INSIDE   = 2'd0,
    HIT_PARALLEL = 2'd1,
    HIT_OUTSIDE  = 2'd2
  } hit_e;

  typedef struct packed {
    hit_e status;
    logic neg_x;
    logic neg_y;
  } tag_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg;
  } fold_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic [4:0] k;
    longint     t;
    k = 5'(i);
    if (k < 5'(ATAN_N)) t = ATAN_TAB[k[3:0]];
    else t = (RAD_UNITS + (64'sd1 << (k - 5'd1))) >>> k;
    return ZW'(t);
  endfunction

  function automatic fold_t ang_fold(input logic signed [AGW-1:0] a);
    logic signed [AGW-1:0] r;
    fold_t                 f;
    r = a;
    if (r < 0) r = r + AGW'(FULL_TURN);
    if (r < 0) r = r + AGW'(FULL_TURN);
    if (r >= AGW'(FULL_TURN)) r = r - AGW'(FULL_TURN);
    if (r >= AGW'(FULL_TURN)) r = r - AGW'(FULL_TURN);
    if (r >= AGW'(HALF_TURN)) r = r - AGW'(FULL_TURN);
    f.neg = 1'b0;
    if (r > AGW'(QUARTER_TURN)) begin
      r     = r - AGW'(HALF_TURN);
      f.neg = 1'b1;
    end else if (r < -AGW'(QUARTER_TURN)) begin
      r     = r + AGW'(HALF_TURN);
      f.neg = 1'b1;
    end
    f.z = {r[ZW-ANG_SHIFT-1:0], {ANG_SHIFT{1'b0}}};
    return f;
  endfunction

  function automatic logic signed [MW-1:0] mul(input logic signed [VW-1:0] a,
                                               input logic signed [VW-1:0] b);
    return MW'(a) * MW'(b);
  endfunction

  function automatic logic signed [VW-1:0] rnd_q(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + PW'(64'sd1 << (FRAC_BITS - 1));
    return t[FRAC_BITS +: VW];
  endfunction

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

endpackage

[sv/rrhl_cordic_cell.sv]
// ----------------------------------------------------------------------------
// rrhl_cordic_cell
// One rotation-mode CORDIC iteration on a single angle, registered.
// ----------------------------------------------------------------------------
module rrhl_cordic_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [rrhl_pkg::STEP_W-1:0]        step_i,
  input  logic signed [rrhl_pkg::CW-1:0]     x_i,
  input  logic signed [rrhl_pkg::CW-1:0]     y_i,
  input  logic signed [rrhl_pkg::ZW-1:0]     z_i,
  output logic signed [rrhl_pkg::CW-1:0]     x_o,
  output logic signed [rrhl_pkg::CW-1:0]     y_o,
  output logic signed [rrhl_pkg::ZW-1:0]     z_o
);
  import rrhl_pkg::*;

  logic signed [CW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;

  always_comb begin
    dx = y_i >>> step_i;
    dy = x_i >>> step_i;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_val(step_i);
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_val(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[sv/rrhl_div_cell.sv]
// ----------------------------------------------------------------------------
// rrhl_div_cell
// One restoring-division step: develop one fraction bit of the quotient.
// ----------------------------------------------------------------------------
module rrhl_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rrhl_pkg::AW-1:0]      r_i,
  input  logic [rrhl_pkg::AW-1:0]      d_i,
  input  logic [rrhl_pkg::QW-1:0]      q_i,
  output logic [rrhl_pkg::AW-1:0]      r_o,
  output logic [rrhl_pkg::AW-1:0]      d_o,
  output logic [rrhl_pkg::QW-1:0]      q_o
);
  import rrhl_pkg::*;

  logic [AW:0]   r2;
  logic          take;
  logic [AW-1:0] r_d, r_q, d_q;
  logic [QW-1:0] q_q;

  always_comb begin
    r2   = {r_i, 1'b0};
    take = (r2 >= {1'b0, d_i});
    r_d  = take ? AW'(r2 - {1'b0, d_i}) : r2[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      d_q <= d_i;
      q_q <= {q_i[QW-2:0], take};
    end
  end

  assign r_o = r_q;
  assign d_o = d_q;
  assign q_o = q_q;

endmodule

[sv/rrhl_geom.sv]
// ----------------------------------------------------------------------------
// rrhl_geom
// Plane, axes and ray arithmetic: dot products, hit coordinates, the
// parallel and inside tests, and the operands of the coordinate division.
// ----------------------------------------------------------------------------
module rrhl_geom (
  input  logic                                clk_i,
  input  logic [rrhl_pkg::GEOM_STAGES-1:0]    en_i,
  input  logic signed [rrhl_pkg::CW-1:0]      cos_i [rrhl_pkg::NLANE],
  input  logic signed [rrhl_pkg::CW-1:0]      sin_i [rrhl_pkg::NLANE],
  input  logic [rrhl_pkg::NLANE-1:0]          neg_i,
  input  logic [rrhl_pkg::DW-1:0]             dist_i,
  input  logic [rrhl_pkg::DW-1:0]             len_i,
  input  logic [rrhl_pkg::DW-1:0]             hgt_i,
  output rrhl_pkg::tag_t                      tag_o,
  output logic [rrhl_pkg::AW-1:0]             rx_o,
  output logic [rrhl_pkg::AW-1:0]             dx_o,
  output logic [rrhl_pkg::AW-1:0]             ry_o,
  output logic [rrhl_pkg::AW-1:0]             dy_o
);
  import rrhl_pkg::*;

  logic signed [VW-1:0] cs [NLANE];
  logic signed [VW-1:0] sn [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      cs[l] = neg_i[l] ? -VW'(cos_i[l]) : VW'(cos_i[l]);
      sn[l] = neg_i[l] ? -VW'(sin_i[l]) : VW'(sin_i[l]);
    end
  end

  // products of the normal and ray
  logic signed [MW-1:0] g1_pct_q, g1_pst_q, g1_pcz_q, g1_psz_q;
  logic signed [VW-1:0] g1_cy_q, g1_sy_q, g1_cw_q, g1_sw_q, g1_sa_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      g1_pct_q <= mul(cs[LANE_YAW], cs[LANE_TILT]);
      g1_pst_q <= mul(cs[LANE_YAW], sn[LANE_TILT]);
      g1_pcz_q <= mul(cs[LANE_ALT], cs[LANE_AZ]);
      g1_psz_q <= mul(cs[LANE_ALT], sn[LANE_AZ]);
      g1_cy_q  <= cs[LANE_YAW];
      g1_sy_q  <= sn[LANE_YAW];
      g1_cw_q  <= cs[LANE_W];
      g1_sw_q  <= sn[LANE_W];
      g1_sa_q  <= sn[LANE_ALT];
    end
  end

  logic signed [VW-1:0] g2_nx_q, g2_ny_q, g2_nz_q, g2_dx_q, g2_dy_q, g2_dz_q;
  logic signed [VW-1:0] g2_cy_q, g2_sy_q, g2_cw_q, g2_sw_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      g2_nx_q <= -rnd_q(PW'(g1_pct_q));
      g2_ny_q <= -g1_sy_q;
      g2_nz_q <= rnd_q(PW'(g1_pst_q));
      g2_dx_q <= rnd_q(PW'(g1_pcz_q));
      g2_dy_q <= rnd_q(PW'(g1_psz_q));
      g2_dz_q <= g1_sa_q;
      g2_cy_q <= g1_cy_q;
      g2_sy_q <= g1_sy_q;
      g2_cw_q <= g1_cw_q;
      g2_sw_q <= g1_sw_q;
    end
  end

  logic signed [MW-1:0] g3_pvx_q, g3_pvy_q, g3_pv1_q, g3_pv2_q;
  logic signed [MW-1:0] g3_pdn0_q, g3_pdn1_q, g3_pdn2_q, g3_pcn0_q, g3_pcn1_q;
  logic signed [MW-1:0] g3_pdu0_q, g3_pdu1_q, g3_pcu0_q, g3_pcu1_q;
  logic signed [VW-1:0] g3_dx_q, g3_dy_q, g3_dz_q, g3_cy_q, g3_sy_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      g3_pvx_q  <= mul(g2_sw_q, g2_nz_q);
      g3_pvy_q  <= mul(g2_cw_q, g2_nz_q);
      g3_pv1_q  <= mul(g2_cw_q, g2_ny_q);
      g3_pv2_q  <= mul(g2_sw_q, g2_nx_q);
      g3_pdn0_q <= mul(g2_dx_q, g2_nx_q);
      g3_pdn1_q <= mul(g2_dy_q, g2_ny_q);
      g3_pdn2_q <= mul(g2_dz_q, g2_nz_q);
      g3_pcn0_q <= mul(g2_cy_q, g2_nx_q);
      g3_pcn1_q <= mul(g2_sy_q, g2_ny_q);
      g3_pdu0_q <= mul(g2_dx_q, g2_cw_q);
      g3_pdu1_q <= mul(g2_dy_q, g2_sw_q);
      g3_pcu0_q <= mul(g2_cy_q, g2_cw_q);
      g3_pcu1_q <= mul(g2_sy_q, g2_sw_q);
      g3_dx_q   <= g2_dx_q;
      g3_dy_q   <= g2_dy_q;
      g3_dz_q   <= g2_dz_q;
      g3_cy_q   <= g2_cy_q;
      g3_sy_q   <= g2_sy_q;
    end
  end

  logic signed [VW-1:0] g4_vx_q, g4_vy_q, g4_vz_q, g4_den_q, g4_cn_q, g4_du_q, g4_cu_q;
  logic signed [VW-1:0] g4_dx_q, g4_dy_q, g4_dz_q, g4_cy_q, g4_sy_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      g4_vx_q  <= rnd_q(PW'(g3_pvx_q));
      g4_vy_q  <= -rnd_q(PW'(g3_pvy_q));
      g4_vz_q  <= rnd_q(PW'(g3_pv1_q) - PW'(g3_pv2_q));
      g4_den_q <= rnd_q(PW'(g3_pdn0_q) + PW'(g3_pdn1_q) + PW'(g3_pdn2_q));
      g4_cn_q  <= rnd_q(PW'(g3_pcn0_q) + PW'(g3_pcn1_q));
      g4_du_q  <= rnd_q(PW'(g3_pdu0_q) + PW'(g3_pdu1_q));
      g4_cu_q  <= rnd_q(PW'(g3_pcu0_q) + PW'(g3_pcu1_q));
      g4_dx_q  <= g3_dx_q;
      g4_dy_q  <= g3_dy_q;
      g4_dz_q  <= g3_dz_q;
      g4_cy_q  <= g3_cy_q;
      g4_sy_q  <= g3_sy_q;
    end
  end

  logic signed [MW-1:0] g5_pdv0_q, g5_pdv1_q, g5_pdv2_q, g5_pcv0_q, g5_pcv1_q;
  logic signed [VW-1:0] g5_cn_q, g5_du_q, g5_cu_q, g5_den_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      g5_pdv0_q <= mul(g4_dx_q, g4_vx_q);
      g5_pdv1_q <= mul(g4_dy_q, g4_vy_q);
      g5_pdv2_q <= mul(g4_dz_q, g4_vz_q);
      g5_pcv0_q <= mul(g4_cy_q, g4_vx_q);
      g5_pcv1_q <= mul(g4_sy_q, g4_vy_q);
      g5_cn_q   <= g4_cn_q;
      g5_du_q   <= g4_du_q;
      g5_cu_q   <= g4_cu_q;
      g5_den_q  <= g4_den_q;
    end
  end

  logic signed [VW-1:0] g6_dv_q, g6_cv_q, g6_cn_q, g6_du_q, g6_cu_q, g6_den_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      g6_dv_q  <= rnd_q(PW'(g5_pdv0_q) + PW'(g5_pdv1_q) + PW'(g5_pdv2_q));
      g6_cv_q  <= rnd_q(PW'(g5_pcv0_q) + PW'(g5_pcv1_q));
      g6_cn_q  <= g5_cn_q;
      g6_du_q  <= g5_du_q;
      g6_cu_q  <= g5_cu_q;
      g6_den_q <= g5_den_q;
    end
  end

  logic signed [MW-1:0] g7_pa_q, g7_pb_q, g7_pc_q, g7_pd_q;
  logic signed [VW-1:0] g7_den_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      g7_pa_q  <= mul(g6_cn_q, g6_du_q);
      g7_pb_q  <= mul(g6_cu_q, g6_den_q);
      g7_pc_q  <= mul(g6_cn_q, g6_dv_q);
      g7_pd_q  <= mul(g6_cv_q, g6_den_q);
      g7_den_q <= g6_den_q;
    end
  end

  logic signed [VW-1:0] xq, yq;
  logic [VW-1:0]        g8_mx_q, g8_my_q, g8_mden_q;
  logic                 g8_sx_q, g8_sy_q, g8_par_q;

  always_comb begin
    xq = rnd_q(PW'(g7_pa_q) - PW'(g7_pb_q));
    yq = rnd_q(PW'(g7_pc_q) - PW'(g7_pd_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      g8_mx_q   <= mag(xq);
      g8_my_q   <= mag(yq);
      g8_mden_q <= mag(g7_den_q);
      g8_sx_q   <= xq[VW-1] ^ g7_den_q[VW-1];
      g8_sy_q   <= yq[VW-1] ^ g7_den_q[VW-1];
      g8_par_q  <= (mag(g7_den_q) < PAR_THR);
    end
  end

  logic [AW-1:0] g9_ax_q, g9_ay_q, g9_bx_q, g9_by_q;
  logic          g9_sx_q, g9_sy_q, g9_par_q, g9_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      g9_ax_q   <= AW'(dist_i) * AW'(g8_mx_q);
      g9_ay_q   <= AW'(dist_i) * AW'(g8_my_q);
      g9_bx_q   <= AW'(len_i) * AW'(g8_mden_q);
      g9_by_q   <= AW'(hgt_i) * AW'(g8_mden_q);
      g9_sx_q   <= g8_sx_q;
      g9_sy_q   <= g8_sy_q;
      g9_par_q  <= g8_par_q;
      g9_zero_q <= (len_i == '0) || (hgt_i == '0);
    end
  end

  logic in_rect;
  tag_t tag_d, tag_q;
  logic [AW-1:0] rx_q, dx_q, ry_q, dy_q;

  always_comb begin
    in_rect = !g9_zero_q && ({g9_ax_q, 1'b0} <= {1'b0, g9_bx_q}) &&
              ({g9_ay_q, 1'b0} <= {1'b0, g9_by_q});
    tag_d.neg_x = g9_sx_q;
    tag_d.neg_y = g9_sy_q;
    if (g9_par_q)     tag_d.status = HIT_PARALLEL;
    else if (in_rect) tag_d.status = HIT_INSIDE;
    else              tag_d.status = HIT_OUTSIDE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      tag_q <= tag_d;
      rx_q  <= g9_ax_q;
      dx_q  <= g9_bx_q;
      ry_q  <= g9_ay_q;
      dy_q  <= g9_by_q;
    end
  end

  assign tag_o = tag_q;
  assign rx_o  = rx_q;
  assign dx_o  = dx_q;
  assign ry_o  = ry_q;
  assign dy_o  = dy_q;

endmodule

[sv/ray_rectangle_hit_locator.sv]
// ----------------------------------------------------------------------------
// ray_rectangle_hit_locator
// Pipeline of 1 + CORDIC_STEPS + 10 + 16 stages (angle register, CORDIC cells,
// geometry stages, division cells) plus the output register.
// Throughput one word per cycle while the output is not stalled; bubbles close up behind a stalled output.
// Rate set by the CORDIC cell chain and the division cell chain, one step
// per cell per cycle. Reset clears all valid flags and loads the register
// defaults; datapath registers are not reset.
// ----------------------------------------------------------------------------
module ray_rectangle_hit_locator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [rrhl_pkg::YAW_W-1:0]             view_yaw_i,
  input  logic signed [rrhl_pkg::ALT_W-1:0]      sun_rel_altitude_i,
  input  logic signed [rrhl_pkg::AZ_W-1:0]       sun_rel_azimuth_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             hit_status_o,
  output logic signed [rrhl_pkg::QW-1:0]         rel_x_o,
  output logic signed [rrhl_pkg::QW-1:0]         rel_y_o,
  input  logic                                   cfg_we_i,
  input  logic [rrhl_pkg::REG_IDX_W-1:0]         cfg_index_i,
  input  logic [rrhl_pkg::DW-1:0]                cfg_wdata_i
);
  import rrhl_pkg::*;

  localparam int CS = CORDIC_STEPS;
  localparam int GS = GEOM_STAGES;
  localparam int DS = DIV_STAGES;
  localparam int NS = 1 + CS + GS + DS;

  logic [DW-1:0]        dist_q, len_q, hgt_q;
  logic signed [TW-1:0] tilt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= DIST_RST;
      len_q  <= LEN_RST;
      hgt_q  <= HGT_RST;
      tilt_q <= TILT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DISTANCE: dist_q <= cfg_wdata_i;
        REG_LENGTH:   len_q  <= cfg_wdata_i;
        REG_HEIGHT:   hgt_q  <= cfg_wdata_i;
        REG_TILT:     tilt_q <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NS-1:0] vld_q;
  logic [NS:0]   free;
  logic          out_vld_q;

  assign free[NS] = !out_vld_q || !out_stall_i;

  for (genvar k = 0; k < NS; k++) begin : g_free
    assign free[k] = free[NS] || !(&vld_q[NS-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (free[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (free[k]) vld_q[k] <= vld_q[k-1];
      end
      if (free[NS]) out_vld_q <= vld_q[NS-1];
    end
  end

  assign in_stall_o = !free[0];

  // angle preparation
  logic signed [AGW-1:0] a_yaw, a_w;
  logic signed [AGW-1:0] ang [NLANE];
  logic signed [ZW-1:0]  z0_q [NLANE];
  logic [NLANE-1:0]      cneg_q [CS+1];
  fold_t                 fold [NLANE];

  always_comb begin
    a_yaw           = AGW'(view_yaw_i);
    a_w             = (a_yaw > AGW'(HALF_TURN)) ? a_yaw - AGW'(QUARTER_TURN)
                                                : a_yaw + AGW'(QUARTER_TURN);
    ang[LANE_YAW]   = a_yaw;
    ang[LANE_TILT]  = AGW'(tilt_q);
    ang[LANE_W]     = a_w;
    ang[LANE_ALT]   = AGW'(sun_rel_altitude_i);
    ang[LANE_AZ]    = AGW'(sun_rel_azimuth_i);
    for (int l = 0; l < NLANE; l++) fold[l] = ang_fold(ang[l]);
  end

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      for (int l = 0; l < NLANE; l++) begin
        z0_q[l]      <= fold[l].z;
        cneg_q[0][l] <= fold[l].neg;
      end
    end
    for (int k = 1; k <= CS; k++) begin
      if (free[k]) cneg_q[k] <= cneg_q[k-1];
    end
  end

  // CORDIC cell chains, one per angle
  logic signed [CW-1:0] xw [NLANE][CS+1];
  logic signed [CW-1:0] yw [NLANE][CS+1];
  logic signed [ZW-1:0] zw [NLANE][CS+1];
  logic signed [CW-1:0] cos_w [NLANE];
  logic signed [CW-1:0] sin_w [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    assign xw[l][0] = CORDIC_X0;
    assign yw[l][0] = '0;
    assign zw[l][0] = z0_q[l];
    for (genvar j = 0; j < CS; j++) begin : g_step
      rrhl_cordic_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (free[1+j]),
        .step_i (STEP_W'(j)),
        .x_i    (xw[l][j]),
        .y_i    (yw[l][j]),
        .z_i    (zw[l][j]),
        .x_o    (xw[l][j+1]),
        .y_o    (yw[l][j+1]),
        .z_o    (zw[l][j+1])
      );
    end
    assign cos_w[l] = xw[l][CS];
    assign sin_w[l] = yw[l][CS];
  end

  tag_t          geom_tag;
  logic [AW-1:0] geom_rx, geom_dx, geom_ry, geom_dy;

  rrhl_geom u_geom (
    .clk_i  (clk_i),
    .en_i   (free[CS+1 +: GS]),
    .cos_i  (cos_w),
    .sin_i  (sin_w),
    .neg_i  (cneg_q[CS]),
    .dist_i (dist_q),
    .len_i  (len_q),
    .hgt_i  (hgt_q),
    .tag_o  (geom_tag),
    .rx_o   (geom_rx),
    .dx_o   (geom_dx),
    .ry_o   (geom_ry),
    .dy_o   (geom_dy)
  );

  // division cell chains for the two coordinates
  logic [AW-1:0] rw [2][DS+1];
  logic [AW-1:0] dw [2][DS+1];
  logic [QW-1:0] qw [2][DS+1];
  tag_t          tag_q [DS];

  assign rw[0][0] = geom_rx;
  assign dw[0][0] = geom_dx;
  assign rw[1][0] = geom_ry;
  assign dw[1][0] = geom_dy;
  assign qw[0][0] = '0;
  assign qw[1][0] = '0;

  for (genvar c = 0; c < 2; c++) begin : g_coord
    for (genvar j = 0; j < DS; j++) begin : g_div
      rrhl_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (free[CS+GS+1+j]),
        .r_i   (rw[c][j]),
        .d_i   (dw[c][j]),
        .q_i   (qw[c][j]),
        .r_o   (rw[c][j+1]),
        .d_o   (dw[c][j+1]),
        .q_o   (qw[c][j+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[CS+GS+1]) tag_q[0] <= geom_tag;
    for (int j = 1; j < DS; j++) begin
      if (free[CS+GS+1+j]) tag_q[j] <= tag_q[j-1];
    end
  end

  // result forming and output register
  tag_t                 last_tag;
  logic [QW-1:0]        qx, qy;
  logic signed [QW-1:0] relx_d, rely_d, relx_q, rely_q;
  logic [1:0]           status_q;

  always_comb begin
    last_tag = tag_q[DS-1];
    qx       = qw[0][DS];
    qy       = qw[1][DS];
    relx_d   = '0;
    rely_d   = '0;
    if (last_tag.status == HIT_INSIDE) begin
      relx_d = last_tag.neg_x ? -qx : (qx[QW-1] ? {1'b0, {(QW-1){1'b1}}} : qx);
      rely_d = last_tag.neg_y ? -qy : (qy[QW-1] ? {1'b0, {(QW-1){1'b1}}} : qy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[NS]) begin
      status_q <= last_tag.status;
      relx_q   <= relx_d;
      rely_q   <= rely_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hit_status_o = status_q;
  assign rel_x_o      = relx_q;
  assign rel_y_o      = rely_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q != HIT_INSIDE) |-> (relx_q == '0) && (rely_q == '0))
    else $error("coordinates non-zero without a hit");

  a_in_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted word not captured");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && !free[NS] |=> vld_q[NS-1])
    else $error("blocked word dropped from last stage");

endmodule
